>>> rtl/base64_stream_decoder_macros.svh
// Assertion macros for the base64 stream decoder checker.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define B64D_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define B64D_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/b64d_pkg.sv
// Shared types, constants and symbol lookup for the base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

	localparam logic [7:0]  SYM_SKIP      = 8'd253;
	localparam logic [7:0]  SYM_PAD       = 8'd254;
	localparam logic [7:0]  SYM_BAD       = 8'd255;
	localparam int          GROUP_SYMBOLS = 4;
	localparam logic [15:0] MAX_LEN_RST   = 16'd2048;
	localparam logic [1:0]  PAD_RST       = 2'd3;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_DONE     = 2'd1,
		KIND_INVALID  = 2'd2,
		KIND_TOO_LONG = 2'd3
	} kind_t;

	// up to three results caused by one character
	typedef struct packed {
		logic [1:0]       n;
		kind_t            kind;
		logic [2:0][7:0]  data;
		logic [2:0][15:0] cnt;
	} bundle_t;

	function automatic logic [7:0] sym_of(input logic [7:0] ch);
		logic [7:0] s;
		if (ch >= 8'd65 && ch <= 8'd90) begin
			s = ch - 8'd65;
		end else if (ch >= 8'd97 && ch <= 8'd122) begin
			s = ch - 8'd97 + 8'd26;
		end else if (ch >= 8'd48 && ch <= 8'd57) begin
			s = ch - 8'd48 + 8'd52;
		end else if (ch == 8'd43) begin
			s = 8'd62;
		end else if (ch == 8'd47) begin
			s = 8'd63;
		end else if (ch == 8'd61) begin
			s = SYM_PAD;
		end else if (ch == 8'd9 || ch == 8'd10 || ch == 8'd13 || ch == 8'd32) begin
			s = SYM_SKIP;
		end else begin
			s = SYM_BAD;
		end
		return s;
	endfunction

endpackage

>>> rtl/b64d_core.sv
// Input register, stream state and per-character decode.
`timescale 1ns / 1ps

module b64d_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	input  logic [7:0]        char_code,
	output logic              char_stall,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  logic              bnd_free,
	output logic              bnd_push,
	output b64d_pkg::bundle_t bnd
);

	logic        vld_s1;
	logic [7:0]  char_s1;
	logic [15:0] maxlen_q;
	logic [23:0] acc_q, acc_d;
	logic [1:0]  sc_q, sc_d;
	logic [1:0]  pad_q, pad_d;
	logic [15:0] idx_q, idx_d;
	logic [15:0] oc_q, oc_d;
	logic [7:0]  sym;
	logic [5:0]  sym6;
	logic [23:0] acc_new;
	logic        adv;
	logic        accept;

	assign sym     = b64d_pkg::sym_of(char_s1);
	assign sym6    = (sym == b64d_pkg::SYM_PAD) ? 6'd0 : sym[5:0];
	assign acc_new = {acc_q[17:0], sym6};

	always_comb begin
		acc_d    = acc_q;
		sc_d     = sc_q;
		pad_d    = pad_q;
		idx_d    = idx_q;
		oc_d     = oc_q;
		bnd      = '0;
		bnd.kind = b64d_pkg::KIND_DATA;
		priority if (char_s1 == 8'd0) begin
			bnd.n    = 2'd1;
			bnd.kind = b64d_pkg::KIND_DONE;
			bnd.cnt  = {3{oc_q}};
		end else if (idx_q >= maxlen_q) begin
			bnd.n    = 2'd1;
			bnd.kind = b64d_pkg::KIND_TOO_LONG;
			bnd.cnt  = {3{oc_q}};
		end else if (sym == b64d_pkg::SYM_BAD) begin
			bnd.n    = 2'd1;
			bnd.kind = b64d_pkg::KIND_INVALID;
			bnd.cnt  = {3{oc_q}};
		end else if (sym == b64d_pkg::SYM_SKIP) begin
			idx_d = idx_q + 16'd1;
		end else begin
			idx_d = idx_q + 16'd1;
			if (sym == b64d_pkg::SYM_PAD && pad_q != 2'd0) begin
				pad_d = pad_q - 2'd1;
			end
			if (sc_q != 2'(b64d_pkg::GROUP_SYMBOLS - 1)) begin
				acc_d = acc_new;
				sc_d  = sc_q + 2'd1;
			end else begin
				acc_d       = '0;
				sc_d        = '0;
				bnd.data[0] = acc_new[23:16];
				bnd.data[1] = acc_new[15:8];
				bnd.data[2] = acc_new[7:0];
				bnd.cnt[0]  = oc_q + 16'd1;
				bnd.cnt[1]  = oc_q + 16'd2;
				bnd.cnt[2]  = oc_q + 16'd3;
				if (pad_d > 2'd2) begin
					bnd.n = 2'd3;
					oc_d  = oc_q + 16'd3;
				end else if (pad_d > 2'd1) begin
					bnd.n = 2'd2;
					oc_d  = oc_q + 16'd2;
				end else begin
					bnd.n = 2'd1;
					oc_d  = oc_q + 16'd1;
				end
			end
		end
		// done and errors restart the stream
		if (bnd.kind != b64d_pkg::KIND_DATA) begin
			acc_d = '0;
			sc_d  = '0;
			pad_d = b64d_pkg::PAD_RST;
			idx_d = '0;
			oc_d  = '0;
		end
	end

	assign adv        = vld_s1 && (bnd.n == 2'd0 || bnd_free);
	assign bnd_push   = adv && bnd.n != 2'd0;
	assign char_stall = vld_s1 && !adv;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			maxlen_q <= b64d_pkg::MAX_LEN_RST;
			acc_q    <= '0;
			sc_q     <= '0;
			pad_q    <= b64d_pkg::PAD_RST;
			idx_q    <= '0;
			oc_q     <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (cfg_we) begin
				maxlen_q <= cfg_data;
			end
			if (adv) begin
				acc_q <= acc_d;
				sc_q  <= sc_d;
				pad_q <= pad_d;
				idx_q <= idx_d;
				oc_q  <= oc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
		end
	end

endmodule

>>> rtl/b64d_outq.sv
// Result register that hands out one word per cycle from a decoded bundle while res_stall is low.
`timescale 1ns / 1ps

module b64d_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              bnd_push,
	input  b64d_pkg::bundle_t bnd,
	output logic              bnd_free,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [7:0]        data_byte,
	output logic [1:0]        kind,
	output logic [15:0]       byte_count,
	output logic              last_of_run
);

	logic              vld_q;
	logic [1:0]        pos_q;
	b64d_pkg::bundle_t bnd_q;
	logic              take;

	assign res_valid   = vld_q;
	assign take        = vld_q && !res_stall;
	assign last_of_run = (pos_q == bnd_q.n - 2'd1);
	assign bnd_free    = !vld_q || (take && last_of_run);
	assign kind        = bnd_q.kind;

	always_comb begin
		unique case (pos_q)
			2'd0: begin
				data_byte  = bnd_q.data[0];
				byte_count = bnd_q.cnt[0];
			end
			2'd1: begin
				data_byte  = bnd_q.data[1];
				byte_count = bnd_q.cnt[1];
			end
			2'd2: begin
				data_byte  = bnd_q.data[2];
				byte_count = bnd_q.cnt[2];
			end
			default: begin
				data_byte  = '0;
				byte_count = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			pos_q <= '0;
		end else begin
			if (bnd_push) begin
				vld_q <= 1'b1;
				pos_q <= '0;
			end else if (take && last_of_run) begin
				vld_q <= 1'b0;
			end else if (take) begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_push) begin
			bnd_q <= bnd;
		end
	end

endmodule

>>> rtl/base64_stream_decoder.sv
// Datapath: an accepted character is held in the input register and decoded, and its words are
//   loaded into the result register, from which the receiver takes the first word.
// Throughput: one character per cycle; a character that closes a group keeps the result
//   register busy until its words are taken, and a word-producing character behind it waits
//   until the register drains.
// Reset (arst_n low, asynchronous): stream state clears, padding level 3, max_length 2048.
`timescale 1ns / 1ps

module base64_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	input  logic [7:0]  char_code,
	output logic        char_stall,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  data_byte,
	output logic [1:0]  kind,
	output logic [15:0] byte_count,
	output logic        last_of_run
);

	b64d_pkg::bundle_t bnd;
	logic              bnd_push;
	logic              bnd_free;

	b64d_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_code  (char_code),
		.char_stall (char_stall),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.bnd_free   (bnd_free),
		.bnd_push   (bnd_push),
		.bnd        (bnd)
	);

	b64d_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.bnd_push    (bnd_push),
		.bnd         (bnd),
		.bnd_free    (bnd_free),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.data_byte   (data_byte),
		.kind        (kind),
		.byte_count  (byte_count),
		.last_of_run (last_of_run)
	);

endmodule

>>> rtl/b64d_checker.sv
// Port-level assertions for the base64 stream decoder, bound to the top level.
`timescale 1ns / 1ps
`include "base64_stream_decoder_macros.svh"

module b64d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [7:0]  data_byte,
	input logic [1:0]  kind,
	input logic [15:0] byte_count,
	input logic        last_of_run
);

	logic        status_w;
	logic        step_w;
	logic        data_w;
	logic [15:0] next_cnt;

	assign status_w = res_valid && kind != b64d_pkg::KIND_DATA;
	assign step_w   = res_valid && !res_stall && !last_of_run;
	assign data_w   = res_valid && kind == b64d_pkg::KIND_DATA;
	assign next_cnt = byte_count + 16'd1;

	`B64D_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid, "stalled word dropped")
	`B64D_ASSERT_IMP(a_status_last, status_w, last_of_run, "status word not last")
	`B64D_ASSERT_IMP(a_status_zero, status_w, data_byte == 8'd0, "status word carries data")
	`B64D_ASSERT_NXT(a_run_cont, step_w, data_w && byte_count == $past(next_cnt), "data run broken")

endmodule

bind base64_stream_decoder b64d_checker u_chk (.*);

>>> sim/tb.sv
// Testbench for the base64 stream decoder: clocked driver and monitor against a local predictor.
`timescale 1ns / 1ps

module tb;

	localparam logic [7:0] END_CHAR = 8'd0;
	localparam logic [7:0] TAB      = 8'd9;
	localparam logic [7:0] LF       = 8'd10;
	localparam logic [7:0] CR       = 8'd13;
	localparam logic [7:0] SPC      = 8'd32;
	localparam logic [7:0] PAD_CHAR = 8'd61;
	localparam int         LIMIT    = 200000;
	localparam int         HOLD_LEN = 80;

	typedef struct packed {
		logic [7:0]        data;
		b64d_pkg::kind_t   kind;
		logic [15:0]       count;
		logic              last;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic [7:0]  char_code = 8'd0;
	logic        char_stall;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_data = 16'd0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [7:0]  data_byte;
	logic [1:0]  kind;
	logic [15:0] byte_count;
	logic        last_of_run;

	base64_stream_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_code  (char_code),
		.char_stall (char_stall),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.data_byte  (data_byte),
		.kind       (kind),
		.byte_count (byte_count),
		.last_of_run(last_of_run)
	);

	always #1 clk = ~clk;

	logic [7:0] char_q[$];
	word_t      want_q[$];
	logic       char_took = 1'b0;
	logic       no_gaps = 1'b0;
	int         hold_reqs = 0;
	int         hold_done = 0;
	int         hold_left = 0;
	int         errors = 0;
	int         cycles = 0;

	// decoder state as predicted
	logic [23:0] acc;
	logic [1:0]  nsym;
	logic [1:0]  pad;
	logic [15:0] idx;
	logic [15:0] out_cnt;
	logic [15:0] len_limit;

	function automatic logic [7:0] six_bit(input logic [7:0] ch);
		if (ch >= "A" && ch <= "Z") return ch - "A";
		if (ch >= "a" && ch <= "z") return ch - "a" + 8'd26;
		if (ch >= "0" && ch <= "9") return ch - "0" + 8'd52;
		if (ch == "+") return 8'd62;
		if (ch == "/") return 8'd63;
		if (ch == PAD_CHAR) return b64d_pkg::SYM_PAD;
		if (ch == TAB || ch == LF || ch == CR || ch == SPC) return b64d_pkg::SYM_SKIP;
		return b64d_pkg::SYM_BAD;
	endfunction

	function automatic void wipe_stream();
		acc = 24'd0;
		nsym = 2'd0;
		pad = b64d_pkg::PAD_RST;
		idx = 16'd0;
		out_cnt = 16'd0;
	endfunction

	function automatic void decode_char(input logic [7:0] ch);
		logic [7:0] s;
		int nb;
		if (ch == END_CHAR) begin
			want_q.push_back(word_t'{8'd0, b64d_pkg::KIND_DONE, out_cnt, 1'b1});
			wipe_stream();
			return;
		end
		if (idx >= len_limit) begin
			want_q.push_back(word_t'{8'd0, b64d_pkg::KIND_TOO_LONG, out_cnt, 1'b1});
			wipe_stream();
			return;
		end
		idx = idx + 16'd1;
		s = six_bit(ch);
		if (s == b64d_pkg::SYM_BAD) begin
			want_q.push_back(word_t'{8'd0, b64d_pkg::KIND_INVALID, out_cnt, 1'b1});
			wipe_stream();
			return;
		end
		if (s == b64d_pkg::SYM_SKIP) return;
		if (s == b64d_pkg::SYM_PAD) begin
			s = 8'd0;
			if (pad != 2'd0) pad = pad - 2'd1;
		end
		acc = {acc[17:0], s[5:0]};
		if (nsym < b64d_pkg::GROUP_SYMBOLS - 1) begin
			nsym = nsym + 2'd1;
			return;
		end
		// padding level is sticky, so it trims every later group too
		nb = 1 + (pad > 2'd1) + (pad > 2'd2);
		for (int k = 0; k < nb; k++) begin
			out_cnt = out_cnt + 16'd1;
			want_q.push_back(word_t'{acc[23 - 8 * k -: 8], b64d_pkg::KIND_DATA, out_cnt,
				k == nb - 1});
		end
		acc = 24'd0;
		nsym = 2'd0;
	endfunction

	function automatic logic [7:0] alpha_char(input logic [5:0] v);
		if (v < 26) return "A" + v;
		if (v < 52) return "a" + (v - 26);
		if (v < 62) return "0" + (v - 52);
		return (v == 62) ? "+" : "/";
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(3))
			0: return TAB;
			1: return LF;
			2: return CR;
			default: return SPC;
		endcase
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
	endtask

	// one stream: mostly well-formed base64 with random content, sometimes damaged
	task automatic add_stream();
		int nbytes, nsyms, npad, noise, spot, k;
		nbytes = $urandom_range(10);
		nsyms = (nbytes / 3) * 4 + ((nbytes % 3 == 0) ? 0 : nbytes % 3 + 1);
		npad = (nbytes % 3 == 0) ? 0 : 3 - nbytes % 3;
		noise = $urandom_range(99);
		spot = $urandom_range(nsyms);
		for (k = 0; k <= nsyms; k++) begin
			if (k == spot) begin
				if (noise < 8)
					char_q.push_back(8'($urandom_range(255)));
				else if (noise < 14)
					char_q.push_back(PAD_CHAR);
				else if (noise < 18)
					char_q.push_back(alpha_char(6'($urandom_range(63))));
			end
			if (k < nsyms) begin
				if ($urandom_range(9) == 0) char_q.push_back(blank_char());
				char_q.push_back(alpha_char(6'($urandom_range(63))));
			end
		end
		for (k = 0; k < npad; k++) char_q.push_back(PAD_CHAR);
		if (noise < 94) char_q.push_back(END_CHAR);
	endtask

	task automatic wait_drained();
		while (char_q.size() != 0 || char_valid || want_q.size() != 0) @(posedge clk);
		// whitespace may still be in flight with nothing expected
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		len_limit = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input logic [15:0] lim, input int n);
		set_limit(lim);
		while (char_q.size() < n) add_stream();
		wait_drained();
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && (!char_valid || char_took)) begin
			if (char_q.size() != 0 && (no_gaps || $urandom_range(99) >= 30)) begin
				char_valid <= 1'b1;
				char_code <= char_q.pop_front();
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_reqs) begin
			hold_done <= hold_reqs;
			hold_left <= HOLD_LEN;
			res_stall <= 1'b1;
		end else begin
			res_stall <= !no_gaps && $urandom_range(99) < 30;
		end
	end

	// monitor
	always @(posedge clk) begin : mon
		word_t w;
		cycles++;
		if (!arst_n) begin
			char_took <= 1'b0;
		end else begin
			char_took <= char_valid && !char_stall;
			if (char_valid && !char_stall) decode_char(char_code);
			if (res_valid && !res_stall) begin
				if (want_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: byte %h kind %0d count %0d last %b",
							data_byte, kind, byte_count, last_of_run);
				end else begin
					w = want_q.pop_front();
					if (data_byte !== w.data || kind !== w.kind || byte_count !== w.count ||
						last_of_run !== w.last) begin
						errors++;
						if (errors <= 10)
							$display("cycle %0d: got %h/%0d/%0d/%b want %h/%0d/%0d/%b",
								cycles, data_byte, kind, byte_count, last_of_run,
								w.data, w.kind, w.count, w.last);
					end
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		len_limit = b64d_pkg::MAX_LEN_RST;
		wipe_stream();
		// edges of the alphabet, whitespace, padding and its floor, invalid byte
		push_text("AZaz");
		char_q.push_back(SPC);
		push_text("09+/");
		char_q.push_back(TAB);
		char_q.push_back(CR);
		char_q.push_back(LF);
		push_text("QQ==");
		push_text("====AAAA");
		char_q.push_back(END_CHAR);
		char_q.push_back(8'hFF);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_drained();

		set_limit(16'd0);
		push_text("A");
		char_q.push_back(END_CHAR);
		wait_drained();

		set_limit(16'd5);
		push_text("AAAAAA");
		wait_drained();

		no_gaps = 1'b1;
		random_phase(16'hFFFF, 120);
		no_gaps = 1'b0;

		hold_reqs++;
		random_phase(16'd40, 120);
		random_phase(16'd7, 80);
		random_phase(16'd0, 20);
		random_phase(b64d_pkg::MAX_LEN_RST, 140);

		repeat (10) @(posedge clk);
		if (errors == 0 && want_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> base64_stream_decoder.f
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_core.sv
rtl/b64d_outq.sv
rtl/base64_stream_decoder.sv
rtl/b64d_checker.sv
sim/tb.sv
